@@ rtl/tf_pkg.sv @@
// ----------------------------------------------------------------------------
// tf_pkg: Twofish shared constants and byte-level functions
// Q permutations, GF(2^8) multiply, keyed h function and MDS mixing.
// ----------------------------------------------------------------------------
`default_nettype none
package tf_pkg;

    localparam int ROUND_COUNT_DEF = 16;
    localparam logic [31:0] RHO = 32'h01010101;
    localparam logic [8:0] MDS_POLY = 9'h169;
    localparam logic [8:0] RS_POLY = 9'h14D;

    localparam logic [1:0] FUNC_EXPAND = 2'd0;
    localparam logic [1:0] FUNC_ENC = 2'd1;
    localparam logic [1:0] FUNC_DEC = 2'd2;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_MODE = 3'd4;

    typedef logic [3:0] nib_t;

    // nibble i of each row is entry i of the small permutation
    function automatic nib_t qt(input logic w, input logic [1:0] t, input nib_t x);
        logic [63:0] row;
        begin
            case ({w, t})
                3'd0: row = 64'h4ACE95B023F6D718;
                3'd1: row = 64'hD9076A4F53218BCE;
                3'd2: row = 64'h17423F8C09D6E5AB;
                3'd3: row = 64'hAC5803B9E6214F7D;
                3'd4: row = 64'h5CA04913E67FDB82;
                3'd5: row = 64'h809F5AD673C4B2E1;
                3'd6: row = 64'hF3B28DE0A96157C4;
                3'd7: row = 64'hA802F746ED3C159B;
                default: row = 64'h0;
            endcase
            qt = row[{x, 2'b00} +: 4];
        end
    endfunction

    function automatic logic [7:0] qperm(input logic w, input logic [7:0] x);
        nib_t a0, b0, a1, b1, a2, b2, a3, b3, a4, b4;
        begin
            a0 = x[7:4]; b0 = x[3:0];
            a1 = a0 ^ b0;
            b1 = a0 ^ {b0[0], b0[3:1]} ^ {a0[0], 3'b000};
            a2 = qt(w, 2'd0, a1); b2 = qt(w, 2'd1, b1);
            a3 = a2 ^ b2;
            b3 = a2 ^ {b2[0], b2[3:1]} ^ {a2[0], 3'b000};
            a4 = qt(w, 2'd2, a3); b4 = qt(w, 2'd3, b3);
            qperm = {b4, a4};
        end
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [8:0] poly);
        logic [8:0] aa;
        logic [7:0] acc;
        begin
            aa = {1'b0, a}; acc = 8'h0;
            for (int i = 0; i < 8; i++)
            begin
                if (b[i]) acc = acc ^ aa[7:0];
                aa = {aa[7:0], 1'b0};
                if (aa[8]) aa = aa ^ poly;
            end
            gmul = acc;
        end
    endfunction

    function automatic logic [31:0] hfun(input logic [31:0] x, input logic [127:0] l,
                                         input logic [1:0] k);
        logic [7:0] y0, y1, y2, y3;
        logic [7:0] z0, z1, z2, z3;
        begin
            y0 = x[7:0]; y1 = x[15:8]; y2 = x[23:16]; y3 = x[31:24];
            if (k == 2'd0)
            begin
                y0 = qperm(1'b1, y0) ^ l[103:96];
                y1 = qperm(1'b0, y1) ^ l[111:104];
                y2 = qperm(1'b0, y2) ^ l[119:112];
                y3 = qperm(1'b1, y3) ^ l[127:120];
            end
            if (k != 2'd2)
            begin
                y0 = qperm(1'b1, y0) ^ l[71:64];
                y1 = qperm(1'b1, y1) ^ l[79:72];
                y2 = qperm(1'b0, y2) ^ l[87:80];
                y3 = qperm(1'b0, y3) ^ l[95:88];
            end
            y0 = qperm(1'b1, qperm(1'b0, qperm(1'b0, y0) ^ l[39:32]) ^ l[7:0]);
            y1 = qperm(1'b0, qperm(1'b0, qperm(1'b1, y1) ^ l[47:40]) ^ l[15:8]);
            y2 = qperm(1'b1, qperm(1'b1, qperm(1'b0, y2) ^ l[55:48]) ^ l[23:16]);
            y3 = qperm(1'b0, qperm(1'b1, qperm(1'b1, y3) ^ l[63:56]) ^ l[31:24]);
            z0 = y0 ^ gmul(8'hEF, y1, MDS_POLY) ^ gmul(8'h5B, y2, MDS_POLY)
                 ^ gmul(8'h5B, y3, MDS_POLY);
            z1 = gmul(8'h5B, y0, MDS_POLY) ^ gmul(8'hEF, y1, MDS_POLY)
                 ^ gmul(8'hEF, y2, MDS_POLY) ^ y3;
            z2 = gmul(8'hEF, y0, MDS_POLY) ^ gmul(8'h5B, y1, MDS_POLY) ^ y2
                 ^ gmul(8'hEF, y3, MDS_POLY);
            z3 = gmul(8'hEF, y0, MDS_POLY) ^ y1 ^ gmul(8'hEF, y2, MDS_POLY)
                 ^ gmul(8'h5B, y3, MDS_POLY);
            hfun = {z3, z2, z1, z0};
        end
    endfunction

    function automatic logic [7:0] rsrow(input logic [1:0] r, input logic [2:0] c);
        logic [255:0] m;
        begin
            m = {64'h039E_DB58_5A87_55A4, 64'h193D_AE47_C1FC_A102,
                 64'hE568_C61E_F382_56A4, 64'h9EDB_585A_8755_A401};
            rsrow = m[{r, c, 3'b000} +: 8];
        end
    endfunction

    function automatic logic [31:0] rsword(input logic [63:0] kp);
        logic [7:0] acc;
        logic [31:0] s;
        begin
            s = 32'h0;
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h0;
                for (int c = 0; c < 8; c++)
                    acc = acc ^ gmul(rsrow(2'(r), 3'(c)), kp[c*8 +: 8], RS_POLY);
                s[r*8 +: 8] = acc;
            end
            rsword = s;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/tf_hunit.sv @@
// ----------------------------------------------------------------------------
// tf_hunit: shared keyed h function unit, registered output
// Two h evaluations side by side, with no busy state; used for both subkey generation and rounds.
// ----------------------------------------------------------------------------
`default_nettype none
module tf_hunit
(
    input  wire logic         clk,
    input  wire logic [31:0]  x0,
    input  wire logic [31:0]  x1,
    input  wire logic [127:0] l0,
    input  wire logic [127:0] l1,
    input  wire logic [1:0]   ksel,
    output logic      [31:0]  h0,
    output logic      [31:0]  h1
);
    always_ff @(posedge clk)
    begin
        h0 <= tf_pkg::hfun(x0, l0, ksel);
        h1 <= tf_pkg::hfun(x1, l1, ksel);
    end
endmodule
`default_nettype wire

@@ rtl/twofish_block_cipher_top.sv @@
// ----------------------------------------------------------------------------
// twofish_block_cipher_top: iterative Twofish core, 128/192/256-bit keys
// Key expansion, encryption and decryption through one shared h unit.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  in      | in_valid, in_stall, func, block_in_*      | input beat
//  out     | out_valid, out_stall, block_out_*, status | output beat
//  cfg     | cfg_we, cfg_index, cfg_data               | register write
// A block passes through the h unit once per round, after input whitening.
// Key expansion makes one subkey pair per pass through the h unit.
// An error or unused-code beat goes straight to the output state.
// out_stall holds a result beat in the output state; in_stall stays
// high from the accepted input beat until the output beat is taken.
// Reset clears key_ready; subkeys are stored in flip-flops cleared at reset.
`default_nettype none
module twofish_block_cipher_top
#(
    parameter int ROUND_COUNT = tf_pkg::ROUND_COUNT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic [63:0] block_in_high,
    input  wire logic [63:0] block_in_low,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [63:0] block_out_high,
    output logic      [63:0] block_out_low,
    output logic             status,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    localparam int NSK = 2 * ROUND_COUNT + 8;
    localparam int NRK = 2 * ROUND_COUNT;
    localparam int RKW = $clog2(NRK);
    localparam int RW = $clog2(ROUND_COUNT);
    localparam int CW = $clog2(NSK / 2 + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_KEY = 2'd1;
    localparam logic [1:0] ST_RND = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    logic [63:0] kp_reg [4];
    logic [1:0] mode_reg;
    logic [31:0] wk_reg [8];     // whitening subkeys 0 to 7
    logic [31:0] rk_reg [NRK];   // round subkeys 8 and up
    logic [127:0] sbk_reg;
    logic [1:0] ksel_reg;   // 0: 4 words, 1: 3 words, 2: 2 words
    logic key_ready_reg;
    logic [1:0] state_reg;
    logic dec_reg;
    logic phase_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0] r_reg [4];
    logic blk_reg;
    logic st_reg;

    logic [31:0] hx0, hx1, h0, h1;
    logic [127:0] hl0, hl1, me_w, mo_w;
    logic [1:0] hk;
    logic [7:0] kx_e, kx_o;
    logic [31:0] a_w, b_w, s0_w, s1_w, f0, f1, r0s, r1s, enc_t, dec_t;
    logic [RW-1:0] rnd;
    logic [RW-1:0] kr_w;
    logic [RKW-1:0] ki0, ki1;
    logic [63:0] wh_w, wl_w;

    // Key words for subkey generation come from the live key registers.
    assign me_w = {kp_reg[3][31:0], kp_reg[2][31:0], kp_reg[1][31:0], kp_reg[0][31:0]};
    assign mo_w = {kp_reg[3][63:32], kp_reg[2][63:32], kp_reg[1][63:32], kp_reg[0][63:32]};
    // Subkey pair index times the byte-replicating constant.
    assign kx_e = 8'({cnt_reg, 1'b0});
    assign kx_o = 8'({cnt_reg, 1'b1});
    assign rnd = dec_reg ? RW'(ROUND_COUNT - 1) - cnt_reg[RW-1:0] : cnt_reg[RW-1:0];
    assign ki0 = {rnd, 1'b0};
    assign ki1 = {rnd, 1'b1};
    assign kr_w = cnt_reg[RW-1:0] - RW'(4);
    assign r0s = dec_reg ? r_reg[2] : r_reg[0];
    assign r1s = dec_reg ? r_reg[3] : r_reg[1];

    always_comb
    begin
        if (state_reg == ST_KEY)
        begin
            hx0 = {4{kx_e}};
            hx1 = {4{kx_o}};
            hl0 = me_w; hl1 = mo_w;
            hk = (mode_reg == 2'd0) ? 2'd2 : (mode_reg == 2'd1) ? 2'd1 : 2'd0;
        end
        else
        begin
            hx0 = r0s;
            hx1 = {r1s[23:0], r1s[31:24]};
            hl0 = sbk_reg; hl1 = sbk_reg;
            hk = ksel_reg;
        end
    end

    tf_hunit u_h (.clk(clk), .x0(hx0), .x1(hx1), .l0(hl0), .l1(hl1), .ksel(hk),
                  .h0(h0), .h1(h1));

    // Subkey pair: h outputs are registered and land in the cycle after their inputs.
    assign a_w = h0;
    assign b_w = {h1[23:0], h1[31:24]};
    assign s0_w = a_w + b_w;
    assign s1_w = a_w + {b_w[30:0], 1'b0};

    // Round function outputs.
    assign f0 = h0 + h1 + rk_reg[ki0];
    assign f1 = h0 + {h1[30:0], 1'b0} + rk_reg[ki1];
    assign enc_t = r_reg[2] ^ f0;
    assign dec_t = r_reg[1] ^ f1;

    // Output whitening from the final round registers.
    always_comb
    begin
        if (!dec_reg)
        begin
            wl_w = {r_reg[3] ^ wk_reg[5], r_reg[2] ^ wk_reg[4]};
            wh_w = {r_reg[1] ^ wk_reg[7], r_reg[0] ^ wk_reg[6]};
        end
        else
        begin
            wl_w = {r_reg[1] ^ wk_reg[1], r_reg[0] ^ wk_reg[0]};
            wh_w = {r_reg[3] ^ wk_reg[3], r_reg[2] ^ wk_reg[2]};
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign block_out_high = blk_reg ? wh_w : 64'h0;
    assign block_out_low = blk_reg ? wl_w : 64'h0;
    assign status = st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) kp_reg[i] <= '0;
            mode_reg <= '0;
            for (int i = 0; i < 8; i++) wk_reg[i] <= '0;
            for (int i = 0; i < NRK; i++) rk_reg[i] <= '0;
            for (int i = 0; i < 4; i++) r_reg[i] <= '0;
            sbk_reg <= '0;
            ksel_reg <= 2'd2;
            key_ready_reg <= 1'b0;
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            cnt_reg <= '0;
            dec_reg <= 1'b0;
            blk_reg <= 1'b0;
            st_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tf_pkg::REG_KEY0: kp_reg[0] <= cfg_data;
                    tf_pkg::REG_KEY1: kp_reg[1] <= cfg_data;
                    tf_pkg::REG_KEY2: kp_reg[2] <= cfg_data;
                    tf_pkg::REG_KEY3: kp_reg[3] <= cfg_data;
                    tf_pkg::REG_MODE: mode_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    phase_reg <= 1'b0;
                    cnt_reg <= '0;
                    if (in_valid)
                    begin
                        blk_reg <= 1'b0;
                        st_reg <= 1'b0;
                        dec_reg <= (func == tf_pkg::FUNC_DEC);
                        if (func == tf_pkg::FUNC_EXPAND)
                        begin
                            // RS words, last word first in the S-box key.
                            if (mode_reg == 2'd0)
                                sbk_reg <= {64'h0, tf_pkg::rsword(kp_reg[0]),
                                            tf_pkg::rsword(kp_reg[1])};
                            else if (mode_reg == 2'd1)
                                sbk_reg <= {32'h0, tf_pkg::rsword(kp_reg[0]),
                                            tf_pkg::rsword(kp_reg[1]),
                                            tf_pkg::rsword(kp_reg[2])};
                            else
                                sbk_reg <= {tf_pkg::rsword(kp_reg[0]),
                                            tf_pkg::rsword(kp_reg[1]),
                                            tf_pkg::rsword(kp_reg[2]),
                                            tf_pkg::rsword(kp_reg[3])};
                            state_reg <= ST_KEY;
                        end
                        else if (func == tf_pkg::FUNC_ENC || func == tf_pkg::FUNC_DEC)
                        begin
                            if (!key_ready_reg)
                            begin
                                st_reg <= 1'b1;
                                state_reg <= ST_OUT;
                            end
                            else
                            begin
                                if (func == tf_pkg::FUNC_ENC)
                                begin
                                    r_reg[0] <= block_in_low[31:0] ^ wk_reg[0];
                                    r_reg[1] <= block_in_low[63:32] ^ wk_reg[1];
                                    r_reg[2] <= block_in_high[31:0] ^ wk_reg[2];
                                    r_reg[3] <= block_in_high[63:32] ^ wk_reg[3];
                                end
                                else
                                begin
                                    r_reg[2] <= block_in_low[31:0] ^ wk_reg[4];
                                    r_reg[3] <= block_in_low[63:32] ^ wk_reg[5];
                                    r_reg[0] <= block_in_high[31:0] ^ wk_reg[6];
                                    r_reg[1] <= block_in_high[63:32] ^ wk_reg[7];
                                end
                                state_reg <= ST_RND;
                            end
                        end
                        else
                            state_reg <= ST_OUT;
                    end
                end
                ST_KEY:
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                    begin
                        // First four pairs are whitening keys, the rest round keys.
                        if (cnt_reg < CW'(4))
                        begin
                            wk_reg[{cnt_reg[1:0], 1'b0}] <= s0_w;
                            wk_reg[{cnt_reg[1:0], 1'b1}] <= {s1_w[22:0], s1_w[31:23]};
                        end
                        else
                        begin
                            rk_reg[{kr_w, 1'b0}] <= s0_w;
                            rk_reg[{kr_w, 1'b1}] <= {s1_w[22:0], s1_w[31:23]};
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CW'(NSK / 2 - 1))
                        begin
                            ksel_reg <= hk;
                            key_ready_reg <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_RND:
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (!dec_reg)
                        begin
                            r_reg[0] <= {enc_t[0], enc_t[31:1]};
                            r_reg[1] <= {r_reg[3][30:0], r_reg[3][31]} ^ f1;
                            r_reg[2] <= r_reg[0];
                            r_reg[3] <= r_reg[1];
                        end
                        else
                        begin
                            r_reg[2] <= {r_reg[0][30:0], r_reg[0][31]} ^ f0;
                            r_reg[3] <= {dec_t[0], dec_t[31:1]};
                            r_reg[0] <= r_reg[2];
                            r_reg[1] <= r_reg[3];
                        end
                        if (cnt_reg == CW'(ROUND_COUNT - 1))
                        begin
                            blk_reg <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT:
                begin
                    // Hold the beat until the receiver takes it.
                    if (!out_stall)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken while result pending");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (block_out_high == 64'h0 && block_out_low == 64'h0))
        else $error("error result not zero");
    a_err_nokey: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> !key_ready_reg) else $error("error with key ready");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(block_out_high)
        && $stable(block_out_low) && $stable(status)))
        else $error("stalled output beat changed");
`endif
endmodule
`default_nettype wire
